// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files of the servo duty slew limiter
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/sdsl_pkg.sv
// shared types and constants for the servo duty slew limiter
// no dependencies
package sdsl_pkg;

    localparam int DUTY_WIDTH_DEF = 16;
    localparam int START_DUTY_DEF = 1048;

    localparam int INTERVAL_W = 16;
    localparam int SIZE_W     = 12;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd10;
    localparam logic [SIZE_W-1:0]     SIZE_RST     = 12'd20;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 1'b1;

    typedef enum logic [1:0] {
        MOTION_IDLE = 2'd0,
        MOTION_UP   = 2'd1,
        MOTION_DOWN = 2'd2
    } motion_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] step_interval_ms;
        logic [SIZE_W-1:0]     step_size;
    } cfg_t;

endpackage

// File: rtl/sdsl_cmd_if.sv
// command channel: valid/ready handshake carrying one input word
// depends on sdsl_pkg
interface sdsl_cmd_if
    import sdsl_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [DUTY_WIDTH-1:0] target_duty;
    logic [TIME_W-1:0]     now_ms;

    modport source (output valid, output mode, output target_duty, output now_ms,
                    input ready);
    modport sink   (input valid, input mode, input target_duty, input now_ms,
                    output ready);
endinterface

// File: rtl/sdsl_res_if.sv
// result channel: valid/ready handshake carrying one result word
// depends on sdsl_pkg
interface sdsl_res_if
    import sdsl_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DUTY_WIDTH-1:0] duty;
    logic [1:0]            motion;
    logic                  stepped;

    modport source (output valid, output duty, output motion, output stepped,
                    input ready);
    modport sink   (input valid, input duty, input motion, input stepped,
                    output ready);
endinterface

// File: rtl/sdsl_cfg.sv
// configuration registers: step interval and step size
// depends on sdsl_pkg
module sdsl_cfg
    import sdsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_STEP_INTERVAL: cfg_next.step_interval_ms = cfg_wdata[INTERVAL_W-1:0];
                REG_STEP_SIZE:     cfg_next.step_size        = cfg_wdata[SIZE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_interval_ms <= INTERVAL_RST;
            cfg_reg.step_size        <= SIZE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/sdsl_step.sv
// next-state logic for one word: retarget on a move, timed ramp step on a process
// depends on sdsl_pkg
module sdsl_step
    import sdsl_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
)
(
    input  cfg_t                  cfg,
    input  logic                  mode,
    input  logic [DUTY_WIDTH-1:0] target,
    input  logic [TIME_W-1:0]     now,
    input  logic [DUTY_WIDTH-1:0] cur,
    input  logic [DUTY_WIDTH-1:0] goal,
    input  motion_t               motion,
    input  logic [TIME_W-1:0]     last_time,
    output logic [DUTY_WIDTH-1:0] cur_next,
    output logic [DUTY_WIDTH-1:0] goal_next,
    output motion_t               motion_next,
    output logic [TIME_W-1:0]     last_time_next,
    output logic                  stepped
);

    // one extra bit so the up sum never wraps and the down difference shows a borrow
    localparam int SUM_W = ((DUTY_WIDTH > SIZE_W) ? DUTY_WIDTH : SIZE_W) + 1;

    logic [SUM_W-1:0]  cur_x;
    logic [SUM_W-1:0]  goal_x;
    logic [SUM_W-1:0]  amt_x;
    logic [SUM_W-1:0]  up_sum;
    logic [SUM_W-1:0]  down_diff;
    logic [TIME_W-1:0] elapsed;
    logic              due;

    assign cur_x     = SUM_W'(cur);
    assign goal_x    = SUM_W'(goal);
    assign amt_x     = SUM_W'(cfg.step_size);
    assign up_sum    = cur_x + amt_x;
    assign down_diff = cur_x - amt_x;
    assign elapsed   = now - last_time;
    assign due       = elapsed >= TIME_W'(cfg.step_interval_ms);

    always_comb
    begin
        cur_next       = cur;
        goal_next      = goal;
        motion_next    = motion;
        last_time_next = last_time;
        stepped        = 1'b0;
        if (mode)
        begin
            goal_next = target;
            if (target > cur)
                motion_next = MOTION_UP;
            else if (target < cur)
                motion_next = MOTION_DOWN;
        end
        else if (motion != MOTION_IDLE && due)
        begin
            last_time_next = now;
            stepped        = 1'b1;
            case (motion)
                MOTION_UP:
                begin
                    if (up_sum >= goal_x)
                    begin
                        cur_next    = goal;
                        motion_next = MOTION_IDLE;
                    end
                    else
                    begin
                        cur_next = up_sum[DUTY_WIDTH-1:0];
                    end
                end
                MOTION_DOWN:
                begin
                    // a step at or past zero clamps instead of wrapping
                    if (amt_x >= cur_x || down_diff <= goal_x)
                    begin
                        cur_next    = goal;
                        motion_next = MOTION_IDLE;
                    end
                    else
                    begin
                        cur_next = down_diff[DUTY_WIDTH-1:0];
                    end
                end
                default:
                begin
                    cur_next = cur;
                end
            endcase
        end
    end

endmodule

// File: rtl/servo_duty_slew_limiter.sv
// channel | dir | payload                         | handshake
// cmd     | in  | mode, target_duty, now_ms       | valid/ready
// res     | out | duty, motion, stepped           | valid/ready
// cfg     | in  | cfg_we, cfg_addr, cfg_wdata     | write enable, no wait
//
// one word per cycle sustained unless res stalls; a word passes the input register
// and then the result register; the ramp state is updated as the word leaves the input
// register, so the loop from the ramp state through sdsl_step sets the rate
// reset (async, active low) empties both stages and loads the start duty
// a stalled result holds both stages; cmd.ready stays high while the input stage can move
//
// top level of the servo duty slew limiter
// depends on sdsl_pkg, sdsl_cmd_if, sdsl_res_if, sdsl_cfg, sdsl_step, assert_macros.svh
`include "assert_macros.svh"

module servo_duty_slew_limiter
    import sdsl_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF,
    parameter int START_DUTY = START_DUTY_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sdsl_cmd_if.sink              cmd,
    sdsl_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [DUTY_WIDTH-1:0] START_VAL = DUTY_WIDTH'(START_DUTY);

    cfg_t cfg;

    // input stage
    logic                  in_valid_reg;
    logic                  in_mode_reg;
    logic [DUTY_WIDTH-1:0] in_target_reg;
    logic [TIME_W-1:0]     in_now_reg;

    // ramp state
    logic [DUTY_WIDTH-1:0] cur_reg;
    logic [DUTY_WIDTH-1:0] goal_reg;
    motion_t               motion_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic [DUTY_WIDTH-1:0] cur_next;
    logic [DUTY_WIDTH-1:0] goal_next;
    motion_t               motion_next;
    logic [TIME_W-1:0]     last_time_next;
    logic                  stepped_next;

    // result stage
    logic                  res_valid_reg;
    logic [DUTY_WIDTH-1:0] res_duty_reg;
    motion_t               res_motion_reg;
    logic                  res_stepped_reg;

    logic advance;
    logic take;

    assign advance   = in_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    sdsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sdsl_step #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_step (
        .cfg            (cfg),
        .mode           (in_mode_reg),
        .target         (in_target_reg),
        .now            (in_now_reg),
        .cur            (cur_reg),
        .goal           (goal_reg),
        .motion         (motion_reg),
        .last_time      (last_time_reg),
        .cur_next       (cur_next),
        .goal_next      (goal_next),
        .motion_next    (motion_next),
        .last_time_next (last_time_next),
        .stepped        (stepped_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            cur_reg       <= START_VAL;
            goal_reg      <= START_VAL;
            motion_reg    <= MOTION_IDLE;
            last_time_reg <= '0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;

            if (advance)
            begin
                cur_reg       <= cur_next;
                goal_reg      <= goal_next;
                motion_reg    <= motion_next;
                last_time_reg <= last_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_mode_reg   <= cmd.mode;
            in_target_reg <= cmd.target_duty;
            in_now_reg    <= cmd.now_ms;
        end
        if (advance)
        begin
            res_duty_reg    <= cur_next;
            res_motion_reg  <= motion_next;
            res_stepped_reg <= stepped_next;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.duty    = res_duty_reg;
    assign res.motion  = res_motion_reg;
    assign res.stepped = res_stepped_reg;

    // idle means the duty sits on its goal
    `ASSERT_IMPLIES(a_idle_at_goal, clk, rst_n, motion_reg == MOTION_IDLE, cur_reg == goal_reg)
    // a ramp never overshoots its goal
    `ASSERT_IMPLIES(a_up_below_goal, clk, rst_n, motion_reg == MOTION_UP, cur_reg <= goal_reg)
    `ASSERT_IMPLIES(a_down_above_goal, clk, rst_n, motion_reg == MOTION_DOWN, cur_reg >= goal_reg)
    // a step records the time of the word that made it
    `ASSERT_NEXT(a_step_time, clk, rst_n, advance && stepped_next, last_time_reg == $past(in_now_reg))

endmodule
